/* sv/weld_torch_cycle_sequencer_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the torch cycle sequencer
// Implication and next-cycle property forms used by wtcs_checker.
// ---------------------------------------------------------------------------
`ifndef WELD_TORCH_CYCLE_SEQUENCER_UNIT_ASSERT_SVH
`define WELD_TORCH_CYCLE_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define WTCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WTCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/wtcs_pkg.sv */
// ---------------------------------------------------------------------------
// wtcs_pkg
// Types, codes and constants of the torch cycle sequencer.
// ---------------------------------------------------------------------------
package wtcs_pkg;

	localparam int COUNT_WIDTH_DEF = 16;

	// phase codes
	localparam logic [2:0] PH_PRE  = 3'd0;
	localparam logic [2:0] PH_WELD = 3'd1;
	localparam logic [2:0] PH_BURN = 3'd2;
	localparam logic [2:0] PH_POST = 3'd3;
	localparam logic [2:0] PH_EXIT = 3'd4;

	// register indexes
	localparam logic [2:0] REG_SEQ_MODE   = 3'd0;
	localparam logic [2:0] REG_CRATER_EN  = 3'd1;
	localparam logic [2:0] REG_CRATER_SPD = 3'd2;
	localparam logic [2:0] REG_PREFLOW    = 3'd3;
	localparam logic [2:0] REG_BURNBACK   = 3'd4;
	localparam logic [2:0] REG_POSTFLOW   = 3'd5;
	localparam logic [2:0] REG_SET_VOLT   = 3'd6;
	localparam logic [2:0] REG_CRATER_VOLT = 3'd7;

	localparam logic [7:0] CRATER_SKIP = 8'd20;
	localparam logic [9:0] VOLT_BURN   = 10'd140;
	localparam logic [9:0] VOLT_FTT    = 10'd190;

	typedef struct packed {
		logic [1:0]  sequence_mode;
		logic        crater_enable;
		logic [7:0]  crater_speed;
		logic [7:0]  preflow_time;
		logic [11:0] burnback_time;
		logic [7:0]  postflow_time;
		logic [9:0]  set_voltage;
		logic [9:0]  crater_voltage;
	} cfg_t;

	typedef struct packed {
		logic       gas;
		logic       motor;
		logic       active;
		logic       pulse;
		logic       cvref;
		logic       cvoff;
		logic       crspd;
		logic       shdn;
		logic [9:0] volt;
	} latch_t;

	typedef struct packed {
		logic [2:0] seq_phase;
		logic       in_cycle;
		logic       timer_running;
		logic       first_release_seen;
		logic       crater_armed;
		logic       release_in_tail;
		latch_t     lat;
	} state_t;

	typedef struct packed {
		logic cycle_start;
		logic motor_stop_wait;
	} pulse_t;

endpackage

/* sv/wtcs_core.sv */
// ---------------------------------------------------------------------------
// wtcs_core
// Next-state and output logic for one control-loop pass.
// ---------------------------------------------------------------------------
module wtcs_core #(
	parameter int COUNT_WIDTH = wtcs_pkg::COUNT_WIDTH_DEF
) (
	input  wtcs_pkg::cfg_t         cfg,
	input  wtcs_pkg::state_t       st,
	input  logic [COUNT_WIDTH-1:0] cnt,
	input  logic                   pressed,
	input  logic                   tick,
	input  logic                   fault,
	output wtcs_pkg::state_t       st_nxt,
	output logic [COUNT_WIDTH-1:0] cnt_nxt,
	output wtcs_pkg::pulse_t       pls
);

	localparam int CMP_W = (COUNT_WIDTH > 12) ? COUNT_WIDTH : 12;

	logic [CMP_W-1:0] pre_thr;
	logic [CMP_W-1:0] burn_thr;
	logic [CMP_W-1:0] post_thr;

	// value * 10 as shift-add
	assign pre_thr  = CMP_W'({cfg.preflow_time, 3'b000}) + CMP_W'({cfg.preflow_time, 1'b0});
	assign post_thr = CMP_W'({cfg.postflow_time, 3'b000}) + CMP_W'({cfg.postflow_time, 1'b0});
	assign burn_thr = CMP_W'(cfg.burnback_time);

	always_comb begin
		wtcs_pkg::state_t       n;
		logic [COUNT_WIDTH-1:0] c;
		logic                   pm;
		logic                   four;
		logic                   start;
		logic                   stopw;

		n     = st;
		c     = cnt;
		pm    = cfg.sequence_mode[1];
		four  = cfg.sequence_mode[0];
		start = 1'b0;
		stopw = 1'b0;

		if (st.timer_running && tick && (c != '1)) begin
			c = c + 1'b1;
		end

		if (pressed || st.in_cycle) begin
			if (!fault) begin
				if (pm) begin
					n.lat.gas = 1'b1;
				end
				if (!n.in_cycle) begin
					n.seq_phase = wtcs_pkg::PH_PRE;
					start = 1'b1;
					if (!pm) begin
						n.lat.crspd = 1'b0;
					end
				end
				if (!four) begin
					unique case (n.seq_phase)
						wtcs_pkg::PH_PRE: begin
							if (pm) begin
								n.lat.shdn = 1'b0;
							end
							if (!n.in_cycle) begin
								n.timer_running = 1'b1;
								c = '0;
								n.lat.cvref = 1'b0;
								n.lat.gas = 1'b1; n.lat.motor = 1'b0; n.lat.active = 1'b1;
								n.in_cycle = 1'b1;
								if (pm) begin
									n.lat.cvoff = 1'b0; n.lat.volt = '0;
								end
							end
							if (CMP_W'(c) >= pre_thr) begin
								n.timer_running = 1'b0;
								c = '0;
								n.lat.cvoff = 1'b1;
								n.lat.volt = pm ? 10'd0 : cfg.set_voltage;
								n.lat.pulse = 1'b1; n.lat.cvref = 1'b0;
								n.lat.gas = 1'b1; n.lat.motor = 1'b1; n.lat.active = 1'b1;
								n.seq_phase = wtcs_pkg::PH_WELD;
							end
							if (!pressed) begin
								n.seq_phase = wtcs_pkg::PH_EXIT;
							end
						end
						wtcs_pkg::PH_WELD: begin
							n.lat.pulse = 1'b1; n.lat.cvref = 1'b0;
							n.lat.cvoff = 1'b1; n.lat.volt = cfg.set_voltage;
							n.lat.gas = 1'b1; n.lat.motor = 1'b1; n.lat.active = 1'b1;
							if (!pressed) begin
								n.timer_running = 1'b1;
								c = '0;
								n.lat.motor = 1'b0;
								n.lat.pulse = 1'b0; n.lat.cvref = 1'b1;
								n.seq_phase = wtcs_pkg::PH_BURN;
								if (pm) begin
									n.lat.volt = wtcs_pkg::VOLT_FTT;
								end
								stopw = 1'b1;
							end
						end
						wtcs_pkg::PH_BURN: begin
							if (CMP_W'(c) >= burn_thr) begin
								n.lat.gas = 1'b1; n.lat.motor = 1'b0; n.lat.active = 1'b1;
								n.timer_running = 1'b1;
								c = '0;
								n.lat.pulse = 1'b0; n.lat.cvref = 1'b1;
								n.lat.cvoff = 1'b0;
								n.lat.volt = pm ? 10'd0 : wtcs_pkg::VOLT_BURN;
								n.seq_phase = wtcs_pkg::PH_POST;
							end
							if (pressed) begin
								n.seq_phase = wtcs_pkg::PH_EXIT;
							end
						end
						wtcs_pkg::PH_POST: begin
							n.lat.cvoff = 1'b0; n.lat.volt = '0;
							if (pm) begin
								n.lat.shdn = 1'b1;
							end
							if (CMP_W'(c) >= post_thr) begin
								n.lat.gas = 1'b0; n.lat.motor = 1'b0; n.lat.active = 1'b1;
								n.timer_running = 1'b0;
								c = '0;
								n.lat.pulse = 1'b0; n.lat.cvref = 1'b0;
								n.seq_phase = wtcs_pkg::PH_EXIT;
							end
							if (pressed) begin
								n.seq_phase = wtcs_pkg::PH_EXIT;
							end
						end
						wtcs_pkg::PH_EXIT: begin
							n.lat.pulse = 1'b0; n.lat.cvref = 1'b0;
							n.lat.cvoff = 1'b0; n.lat.volt = '0;
							n.lat.gas = 1'b0; n.lat.motor = 1'b0; n.lat.active = 1'b0;
							n.timer_running = 1'b0;
							c = '0;
							n.in_cycle = 1'b0;
						end
						default: begin
						end
					endcase
				end else begin
					unique case (n.seq_phase)
						wtcs_pkg::PH_PRE: begin
							if (pm) begin
								n.lat.shdn = 1'b0;
							end
							if (!n.in_cycle) begin
								n.timer_running = 1'b1;
								c = '0;
								n.lat.gas = 1'b1; n.lat.motor = 1'b0; n.lat.active = 1'b1;
								n.lat.pulse = 1'b0; n.lat.cvref = 1'b0;
								n.lat.cvoff = 1'b0; n.lat.volt = '0;
								n.in_cycle = 1'b1;
							end else if (CMP_W'(c) >= pre_thr) begin
								n.timer_running = 1'b0;
								c = '0;
								n.lat.pulse = 1'b1; n.lat.cvref = 1'b0;
								n.lat.cvoff = 1'b1; n.lat.volt = '0;
								n.lat.gas = 1'b1; n.lat.motor = pm; n.lat.active = 1'b1;
								n.seq_phase = wtcs_pkg::PH_WELD;
							end
						end
						wtcs_pkg::PH_WELD: begin
							if (!pressed && !n.first_release_seen) begin
								n.first_release_seen = 1'b1;
								n.lat.pulse = 1'b1; n.lat.cvref = 1'b0;
								if (pm) begin
									n.lat.cvoff = 1'b1;
								end
								n.lat.volt = cfg.set_voltage;
								n.lat.gas = 1'b1; n.lat.motor = 1'b1; n.lat.active = 1'b1;
							end else if (!pressed && !n.crater_armed) begin
								n.lat.pulse = 1'b1; n.lat.cvref = 1'b0;
								n.lat.cvoff = 1'b1; n.lat.volt = cfg.set_voltage;
								n.lat.gas = 1'b1; n.lat.motor = 1'b1; n.lat.active = 1'b1;
							end else if (pressed && n.first_release_seen && !n.crater_armed) begin
								n.lat.pulse = 1'b1; n.lat.cvref = 1'b0;
								n.lat.cvoff = 1'b1; n.lat.volt = cfg.crater_voltage;
								n.lat.gas = 1'b1; n.lat.motor = 1'b1; n.lat.active = 1'b1;
								if (cfg.crater_speed <= wtcs_pkg::CRATER_SKIP) begin
									n.lat.motor = 1'b0;
									n.lat.crspd = 1'b0;
									n.crater_armed = 1'b0;
									stopw = 1'b1;
									if (pm) begin
										n.lat.volt = '0;
									end else begin
										n.timer_running = 1'b1;
										c = '0;
										n.lat.volt = wtcs_pkg::VOLT_FTT;
										n.seq_phase = wtcs_pkg::PH_BURN;
									end
								end else begin
									n.lat.crspd = 1'b1;
									n.crater_armed = 1'b1;
								end
							end else if (n.first_release_seen && n.crater_armed &&
									(pressed == cfg.crater_enable)) begin
								n.timer_running = 1'b1;
								c = '0;
								n.lat.pulse = 1'b0; n.lat.cvref = 1'b1;
								n.lat.cvoff = 1'b1;
								n.lat.volt = pm ? cfg.crater_voltage : wtcs_pkg::VOLT_BURN;
								if (pm) begin
									n.lat.crspd = 1'b0;
								end
								n.lat.gas = 1'b1; n.lat.motor = 1'b0; n.lat.active = 1'b1;
								n.seq_phase = wtcs_pkg::PH_BURN;
								stopw = 1'b1;
							end
						end
						wtcs_pkg::PH_BURN, wtcs_pkg::PH_POST: begin
							if (n.seq_phase == wtcs_pkg::PH_BURN) begin
								if (CMP_W'(c) >= burn_thr) begin
									n.lat.pulse = 1'b0; n.lat.cvref = 1'b1;
									n.lat.cvoff = 1'b0; n.lat.volt = '0;
									n.lat.gas = 1'b1; n.lat.motor = 1'b0; n.lat.active = 1'b1;
									n.timer_running = 1'b1;
									c = '0;
									n.seq_phase = wtcs_pkg::PH_POST;
								end
							end else begin
								if (pm) begin
									n.lat.cvoff = 1'b0; n.lat.volt = '0;
									n.lat.shdn = 1'b1;
								end
								if (CMP_W'(c) >= post_thr) begin
									n.lat.pulse = 1'b0; n.lat.cvref = 1'b0;
									n.lat.cvoff = 1'b0; n.lat.volt = '0;
									n.lat.gas = 1'b0; n.lat.motor = 1'b0; n.lat.active = 1'b1;
									n.timer_running = 1'b0;
									c = '0;
									n.seq_phase = wtcs_pkg::PH_EXIT;
								end
							end
							if (!pressed && !n.release_in_tail) begin
								n.release_in_tail = 1'b1;
							end else if (pressed && n.release_in_tail) begin
								n.seq_phase = wtcs_pkg::PH_EXIT;
							end
						end
						wtcs_pkg::PH_EXIT: begin
							if (!pressed) begin
								n.lat.pulse = 1'b0; n.lat.cvref = 1'b0;
								n.lat.cvoff = 1'b0; n.lat.volt = '0;
								n.lat.gas = 1'b0; n.lat.motor = 1'b0; n.lat.active = 1'b0;
								n.timer_running = 1'b0;
								c = '0;
								n.in_cycle = 1'b0;
								n.first_release_seen = 1'b0;
								n.release_in_tail = 1'b0;
								n.crater_armed = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end else begin
			// idle torch: references off
			n.lat.cvoff = 1'b0;
			n.lat.volt = '0;
		end

		st_nxt              = n;
		cnt_nxt             = c;
		pls.cycle_start     = start;
		pls.motor_stop_wait = stopw;
	end

endmodule

/* sv/weld_torch_cycle_sequencer_unit.sv */
// ---------------------------------------------------------------------------
// weld_torch_cycle_sequencer_unit
// 2T/4T MIG and pulse-MIG torch cycle sequencer, one result item per item.
// ---------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   s_tvalid / s_tready     s_tdata[7:0]
// m_axis    out  m_tvalid / m_tready     m_tdata[23:0]
// cfg       in   cfg_we                  cfg_idx[2:0], cfg_data[11:0]
//
// Each item passes the input register, then one pass of the phase logic into
// the result register. One item per cycle is sustained while the result is
// taken; the state update loops st_q through wtcs_core. Reset clears the phase
// state, the output latches and the settings. A stalled result holds the pipe;
// s_tready drops only when both the input and result registers are full.
// ---------------------------------------------------------------------------
module weld_torch_cycle_sequencer_unit #(
	parameter int COUNT_WIDTH = wtcs_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] torch_pressed, [1] tick, [2] fault
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] gas_on, [1] motor_on, [2] cycle_active,
	                               // [3] pulse_enable, [4] cv_ref_on, [14:5] voltage_ref,
	                               // [15] cv_offset_on, [16] crater_speed_on, [19:17] phase,
	                               // [20] force_shutdown, [21] cycle_start,
	                               // [22] motor_stop_wait
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [11:0] cfg_data
);

	wtcs_pkg::cfg_t         cfg_q;
	wtcs_pkg::state_t       st_q;
	wtcs_pkg::state_t       st_nxt;
	wtcs_pkg::pulse_t       pls;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] cnt_nxt;

	logic       valid_s1;
	logic [2:0] in_s1;
	logic       adv;
	logic       out_valid_q;
	logic [22:0] res_q;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				wtcs_pkg::REG_SEQ_MODE:    cfg_q.sequence_mode  <= cfg_data[1:0];
				wtcs_pkg::REG_CRATER_EN:   cfg_q.crater_enable  <= cfg_data[0];
				wtcs_pkg::REG_CRATER_SPD:  cfg_q.crater_speed   <= cfg_data[7:0];
				wtcs_pkg::REG_PREFLOW:     cfg_q.preflow_time   <= cfg_data[7:0];
				wtcs_pkg::REG_BURNBACK:    cfg_q.burnback_time  <= cfg_data;
				wtcs_pkg::REG_POSTFLOW:    cfg_q.postflow_time  <= cfg_data[7:0];
				wtcs_pkg::REG_SET_VOLT:    cfg_q.set_voltage    <= cfg_data[9:0];
				wtcs_pkg::REG_CRATER_VOLT: cfg_q.crater_voltage <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_s1 <= s_tdata[2:0];
		end
	end

	wtcs_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.cfg     (cfg_q),
		.st      (st_q),
		.cnt     (cnt_q),
		.pressed (in_s1[0]),
		.tick    (in_s1[1]),
		.fault   (in_s1[2]),
		.st_nxt  (st_nxt),
		.cnt_nxt (cnt_nxt),
		.pls     (pls)
	);

	// all-zero state is pre-flow, not in a cycle, latches off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				st_q  <= st_nxt;
				cnt_q <= cnt_nxt;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= {pls.motor_stop_wait, pls.cycle_start, st_nxt.lat.shdn,
				st_nxt.seq_phase, st_nxt.lat.crspd, st_nxt.lat.cvoff, st_nxt.lat.volt,
				st_nxt.lat.cvref, st_nxt.lat.pulse, st_nxt.lat.active,
				st_nxt.lat.motor, st_nxt.lat.gas};
		end
	end

endmodule

/* sv/wtcs_checker.sv */
// ---------------------------------------------------------------------------
// wtcs_checker
// Port-level checks of the torch cycle sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`include "weld_torch_cycle_sequencer_unit_assert.svh"

module wtcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	logic stalled;
	logic out_start;
	logic out_stopw;

	assign stalled   = m_tvalid && !m_tready;
	assign out_start = m_tvalid && m_tdata[21];
	assign out_stopw = m_tvalid && m_tdata[22];

	`WTCS_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, m_tvalid && $stable(m_tdata), "stall change")
	`WTCS_ASSERT_IMPLY(a_start_active, clk, arst_n, out_start, m_tdata[2] && m_tdata[0], "bad start")
	`WTCS_ASSERT_IMPLY(a_stopwait_motor, clk, arst_n, out_stopw, !m_tdata[1], "stop with motor")
	`WTCS_ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_tvalid, !m_tdata[23], "padding bit set")
	`WTCS_ASSERT_IMPLY(a_ready_empty, clk, arst_n, !m_tvalid, s_tready, "not ready when empty")

endmodule

bind weld_torch_cycle_sequencer_unit wtcs_checker u_wtcs_checker (.*);
